// ===== design/arp_pkg.sv =====
package arp_pkg;

  localparam int IDX_W      = 12;
  localparam int CHAR_W     = 8;
  localparam int DIM_CFG_W  = 7;
  localparam int SHIFT_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH   = 2'd0,
    REG_GRID_HEIGHT  = 2'd1,
    REG_SHIFT_AMOUNT = 2'd2,
    REG_DECRYPT_MODE = 2'd3
  } reg_sel_t;

  localparam logic [DIM_CFG_W-1:0] GRID_WIDTH_RST  = 7'd8;
  localparam logic [DIM_CFG_W-1:0] GRID_HEIGHT_RST = 7'd8;
  localparam logic [SHIFT_W-1:0]   SHIFT_RST       = 8'd3;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [CHAR_W-1:0] ch;
    logic              bypass;
  } front_t;

endpackage

// ===== design/arp_if.sv =====
interface arp_in_if;
  logic                        valid;
  logic                        ready;
  logic [arp_pkg::IDX_W-1:0]   cell_index;
  logic [arp_pkg::CHAR_W-1:0]  char_in;

  modport source (output valid, output cell_index, output char_in, input ready);
  modport sink (input valid, input cell_index, input char_in, output ready);
endinterface

interface arp_out_if;
  logic                        valid;
  logic                        ready;
  logic [arp_pkg::IDX_W-1:0]   dest_index;
  logic [arp_pkg::CHAR_W-1:0]  char_out;

  modport source (output valid, output dest_index, output char_out, input ready);
  modport sink (input valid, input dest_index, input char_out, output ready);
endinterface

// ===== design/antidiagonal_rotation_permuter.sv =====
// pipeline: front register, cell_index/width divider steps, geometry, shift % len divider steps, rotation, map, output
// throughput: one transaction per cycle unless dest.ready stalls the output, one restoring-division step per stage
// stall: each stage moves when empty or when its successor moves, bubbles are squeezed out
// reset: synchronous, clears every stage valid and loads width 8, height 8, shift 3, encrypt
module antidiagonal_rotation_permuter #(
  parameter int MAX_DIM = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [arp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [arp_pkg::CFG_DATA_W-1:0]  cfg_data,
  arp_in_if.sink                          src,
  arp_out_if.source                       dest
);

  localparam int IDX_W   = arp_pkg::IDX_W;
  localparam int CHAR_W  = arp_pkg::CHAR_W;
  localparam int SHIFT_W = arp_pkg::SHIFT_W;
  localparam int DIM_MAX = (MAX_DIM < 127) ? MAX_DIM : 127;
  localparam int DIM_W   = $clog2(DIM_MAX + 1);
  localparam int Q1_W    = $clog2(DIM_MAX);
  localparam int D_W     = $clog2(2 * DIM_MAX - 1);
  localparam int AREA_W  = 2 * DIM_W;
  localparam int T_W     = DIM_W + 1;
  localparam int PROD_W  = Q1_W + DIM_W;
  localparam int FRONT_W = $bits(arp_pkg::front_t);

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [CHAR_W-1:0] ch;
    logic              bypass;
    logic [D_W-1:0]    d;
    logic [Q1_W-1:0]   top;
    logic [DIM_W-1:0]  len;
    logic [Q1_W-1:0]   pos;
  } geo_t;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [CHAR_W-1:0] ch;
    logic              bypass;
    logic [D_W-1:0]    d;
    logic [Q1_W-1:0]   top;
    logic [Q1_W-1:0]   npos;
  } rot_t;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [CHAR_W-1:0] ch;
    logic              bypass;
    logic [IDX_W-1:0]  prod;
    logic [Q1_W-1:0]   ncol;
  } map_t;

  localparam int GEO_W = $bits(geo_t);

  // configuration
  logic [arp_pkg::DIM_CFG_W-1:0] grid_width;
  logic [arp_pkg::DIM_CFG_W-1:0] grid_height;
  logic [SHIFT_W-1:0]            shift_amount;
  logic                          decrypt_mode;
  logic [DIM_W-1:0]              w_c;
  logic [DIM_W-1:0]              h_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width   <= arp_pkg::GRID_WIDTH_RST;
      grid_height  <= arp_pkg::GRID_HEIGHT_RST;
      shift_amount <= arp_pkg::SHIFT_RST;
      decrypt_mode <= 1'b0;
    end else if (cfg_we) begin
      case (arp_pkg::reg_sel_t'(cfg_index))
        arp_pkg::REG_GRID_WIDTH:   grid_width   <= cfg_data[arp_pkg::DIM_CFG_W-1:0];
        arp_pkg::REG_GRID_HEIGHT:  grid_height  <= cfg_data[arp_pkg::DIM_CFG_W-1:0];
        arp_pkg::REG_SHIFT_AMOUNT: shift_amount <= cfg_data[SHIFT_W-1:0];
        arp_pkg::REG_DECRYPT_MODE: decrypt_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_c = (32'(grid_width) > MAX_DIM) ? DIM_W'(DIM_MAX) : DIM_W'(grid_width);
    h_c = (32'(grid_height) > MAX_DIM) ? DIM_W'(DIM_MAX) : DIM_W'(grid_height);
  end

  // stage valids and enables
  logic              front_vld, geom_vld, rot_vld, map_vld, out_vld;
  logic              en_front, en_geom, en_rot, en_map, en_out;
  logic [Q1_W-1:0]   div1_vld, div1_en;
  logic [SHIFT_W-1:0] div2_vld, div2_en;

  assign en_out   = !out_vld || dest.ready;
  assign en_map   = !map_vld || en_out;
  assign en_rot   = !rot_vld || en_map;
  assign en_geom  = !geom_vld || div2_en[0];
  assign en_front = !front_vld || div1_en[0];
  assign src.ready = en_front;

  // front: bounds check
  arp_pkg::front_t    front_side;
  logic [AREA_W-1:0]  area;

  assign area = AREA_W'(w_c) * AREA_W'(h_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      front_vld <= 1'b0;
    end else if (en_front) begin
      front_vld <= src.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_front) begin
      front_side.idx    <= src.cell_index;
      front_side.ch     <= src.char_in;
      front_side.bypass <= (w_c == '0) || (h_c == '0) ||
                           (32'(src.cell_index) >= 32'(area));
    end
  end

  // row and column: cell_index / width
  logic [IDX_W-1:0]   div1_rem  [Q1_W];
  logic [Q1_W-1:0]    div1_quo  [Q1_W];
  logic [FRONT_W-1:0] div1_side [Q1_W];

  for (genvar i = 0; i < Q1_W; i++) begin : g_div1
    logic              v_in;
    logic [IDX_W-1:0]  r_in;
    logic [Q1_W-1:0]   q_in;
    logic [FRONT_W-1:0] s_in;

    if (i == 0) begin : g_first
      assign v_in = front_vld;
      assign r_in = front_side.idx;
      assign q_in = '0;
      assign s_in = front_side;
    end else begin : g_next
      assign v_in = div1_vld[i-1];
      assign r_in = div1_rem[i-1];
      assign q_in = div1_quo[i-1];
      assign s_in = div1_side[i-1];
    end

    if (i == Q1_W - 1) begin : g_en_last
      assign div1_en[i] = !div1_vld[i] || en_geom;
    end else begin : g_en_mid
      assign div1_en[i] = !div1_vld[i] || div1_en[i+1];
    end

    arp_div_step #(
      .NUM_W  (IDX_W),
      .DEN_W  (DIM_W),
      .QUO_W  (Q1_W),
      .STEP   (Q1_W - 1 - i),
      .SIDE_W (FRONT_W)
    ) u_step (
      .clk      (clk),
      .rst      (rst),
      .en       (div1_en[i]),
      .valid_in (v_in),
      .rem_in   (r_in),
      .quo_in   (q_in),
      .den      (w_c),
      .side_in  (s_in),
      .valid    (div1_vld[i]),
      .rem      (div1_rem[i]),
      .quo      (div1_quo[i]),
      .side     (div1_side[i])
    );
  end

  // diagonal geometry
  arp_pkg::front_t g_side;
  logic [D_W-1:0]  g_r, g_c, g_d, g_wm1, g_hm1, g_top, g_bot, g_len, g_pos;
  geo_t            geo;

  always_comb begin
    g_side = arp_pkg::front_t'(div1_side[Q1_W-1]);
    g_r    = D_W'(div1_quo[Q1_W-1]);
    g_c    = D_W'(div1_rem[Q1_W-1][Q1_W-1:0]);
    g_d    = g_r + g_c;
    g_wm1  = D_W'(w_c) - D_W'(1);
    g_hm1  = D_W'(h_c) - D_W'(1);
    g_top  = (g_d > g_wm1) ? g_d - g_wm1 : '0;
    g_bot  = (g_d < g_hm1) ? g_d : g_hm1;
    g_len  = g_bot - g_top + D_W'(1);
    g_pos  = g_r - g_top;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      geom_vld <= 1'b0;
    end else if (en_geom) begin
      geom_vld <= div1_vld[Q1_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en_geom) begin
      geo.idx    <= g_side.idx;
      geo.ch     <= g_side.ch;
      geo.bypass <= g_side.bypass;
      geo.d      <= g_d;
      geo.top    <= g_top[Q1_W-1:0];
      geo.len    <= g_len[DIM_W-1:0];
      geo.pos    <= g_pos[Q1_W-1:0];
    end
  end

  // key reduction: shift_amount % len
  logic [SHIFT_W-1:0] div2_rem  [SHIFT_W];
  logic [SHIFT_W-1:0] div2_quo  [SHIFT_W];
  logic [GEO_W-1:0]   div2_side [SHIFT_W];

  for (genvar j = 0; j < SHIFT_W; j++) begin : g_div2
    logic               v_in;
    logic [SHIFT_W-1:0] r_in;
    logic [SHIFT_W-1:0] q_in;
    logic [GEO_W-1:0]   s_in;
    logic [DIM_W-1:0]   den;

    if (j == 0) begin : g_first
      assign v_in = geom_vld;
      assign r_in = shift_amount;
      assign q_in = '0;
      assign s_in = geo;
      assign den  = geo.len;
    end else begin : g_next
      geo_t s_prev;
      assign s_prev = geo_t'(div2_side[j-1]);
      assign v_in = div2_vld[j-1];
      assign r_in = div2_rem[j-1];
      assign q_in = div2_quo[j-1];
      assign s_in = div2_side[j-1];
      assign den  = s_prev.len;
    end

    if (j == SHIFT_W - 1) begin : g_en_last
      assign div2_en[j] = !div2_vld[j] || en_rot;
    end else begin : g_en_mid
      assign div2_en[j] = !div2_vld[j] || div2_en[j+1];
    end

    arp_div_step #(
      .NUM_W  (SHIFT_W),
      .DEN_W  (DIM_W),
      .QUO_W  (SHIFT_W),
      .STEP   (SHIFT_W - 1 - j),
      .SIDE_W (GEO_W)
    ) u_step (
      .clk      (clk),
      .rst      (rst),
      .en       (div2_en[j]),
      .valid_in (v_in),
      .rem_in   (r_in),
      .quo_in   (q_in),
      .den      (den),
      .side_in  (s_in),
      .valid    (div2_vld[j]),
      .rem      (div2_rem[j]),
      .quo      (div2_quo[j]),
      .side     (div2_side[j])
    );
  end

  // rotation along the diagonal
  geo_t           k_geo;
  logic [T_W-1:0] k_val, t_fwd, t_bwd, t_sel, t_wrap, t_len;
  rot_t           rot;

  always_comb begin
    k_geo  = geo_t'(div2_side[SHIFT_W-1]);
    k_val  = T_W'(div2_rem[SHIFT_W-1][Q1_W-1:0]);
    t_len  = T_W'(k_geo.len);
    t_fwd  = T_W'(k_geo.pos) + k_val;
    t_bwd  = T_W'(k_geo.pos) + t_len - k_val;
    t_sel  = decrypt_mode ? t_bwd : t_fwd;
    t_wrap = (t_sel >= t_len) ? t_sel - t_len : t_sel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_vld <= 1'b0;
    end else if (en_rot) begin
      rot_vld <= div2_vld[SHIFT_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en_rot) begin
      rot.idx    <= k_geo.idx;
      rot.ch     <= k_geo.ch;
      rot.bypass <= k_geo.bypass;
      rot.d      <= k_geo.d;
      rot.top    <= k_geo.top;
      rot.npos   <= t_wrap[Q1_W-1:0];
    end
  end

  // back to row-major
  logic [Q1_W-1:0]   m_nrow;
  logic [D_W-1:0]    m_ncol;
  logic [PROD_W-1:0] m_prod;
  map_t              map_r;

  always_comb begin
    m_nrow = rot.top + rot.npos;
    m_ncol = rot.d - D_W'(m_nrow);
    m_prod = PROD_W'(m_nrow) * PROD_W'(w_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      map_vld <= 1'b0;
    end else if (en_map) begin
      map_vld <= rot_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en_map) begin
      map_r.idx    <= rot.idx;
      map_r.ch     <= rot.ch;
      map_r.bypass <= rot.bypass;
      map_r.prod   <= IDX_W'(m_prod);
      map_r.ncol   <= m_ncol[Q1_W-1:0];
    end
  end

  // output register
  logic [IDX_W-1:0]  out_index;
  logic [CHAR_W-1:0] out_char;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en_out) begin
      out_vld <= map_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_index <= map_r.bypass ? map_r.idx : map_r.prod + IDX_W'(map_r.ncol);
      out_char  <= map_r.ch;
    end
  end

  assign dest.valid      = out_vld;
  assign dest.dest_index = out_index;
  assign dest.char_out   = out_char;

endmodule

// ===== design/arp_div_step.sv =====
module arp_div_step #(
  parameter int NUM_W  = 12,
  parameter int DEN_W  = 7,
  parameter int QUO_W  = 6,
  parameter int STEP   = 0,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              valid_in,
  input  logic [NUM_W-1:0]  rem_in,
  input  logic [QUO_W-1:0]  quo_in,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              valid,
  output logic [NUM_W-1:0]  rem,
  output logic [QUO_W-1:0]  quo,
  output logic [SIDE_W-1:0] side
);

  localparam int CMP_W = (NUM_W > DEN_W + STEP) ? NUM_W : DEN_W + STEP;

  logic [CMP_W-1:0] num_ext;
  logic [CMP_W-1:0] den_ext;
  logic [CMP_W-1:0] diff;
  logic             take;

  always_comb begin
    num_ext = CMP_W'(rem_in);
    den_ext = CMP_W'(den) << STEP;
    take    = (num_ext >= den_ext);
    diff    = num_ext - den_ext;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem  <= take ? diff[NUM_W-1:0] : rem_in;
      quo  <= quo_in | (QUO_W'(take) << STEP);
      side <= side_in;
    end
  end

endmodule

// ===== test/antidiagonal_rotation_permuter_test.sv =====
`timescale 1ns / 1ps

module antidiagonal_rotation_permuter_test;

  localparam int IDX_W       = arp_pkg::IDX_W;
  localparam int CHAR_W      = arp_pkg::CHAR_W;
  localparam int CFG_IDX_W   = arp_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W  = arp_pkg::CFG_DATA_W;
  localparam int DIM_CFG_W   = arp_pkg::DIM_CFG_W;
  localparam int SHIFT_W     = arp_pkg::SHIFT_W;
  localparam int GRID_LIMIT  = 64;
  localparam int PHASES      = 10;
  localparam int PHASE_CELLS = 110;
  localparam int PLAN_ROWS   = 23;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [IDX_W-1:0]  dest;
    logic [CHAR_W-1:0] ch;
  } cell_result_t;

  typedef struct packed {
    bit             set_grid;
    bit [7:0]       w;
    bit [7:0]       h;
    bit [7:0]       shift;
    bit [7:0]       back;
    bit [IDX_W-1:0] idx;
    bit [7:0]       ch;
    bit             known;
    bit [IDX_W-1:0] dest;
  } plan_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  arp_in_if  cell_bus ();
  arp_out_if dest_bus ();

  antidiagonal_rotation_permuter uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .src       (cell_bus),
    .dest      (dest_bus)
  );

  logic [DIM_CFG_W-1:0] grid_w;
  logic [DIM_CFG_W-1:0] grid_h;
  logic [SHIFT_W-1:0]   rot_shift;
  logic                 rot_back;

  cell_result_t pending_cells[$];
  int mismatches = 0;
  int cycles = 0;
  bit send_calm = 0;
  bit take_calm = 0;
  plan_row_t plan [PLAN_ROWS];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int unsigned clamped(logic [DIM_CFG_W-1:0] v);
    return (v > GRID_LIMIT) ? GRID_LIMIT : v;
  endfunction

  // position after rotating the cell along its anti-diagonal
  function automatic logic [IDX_W-1:0] rotated_cell(logic [IDX_W-1:0] idx);
    int unsigned w, h, r, c, d, top, bottom, len, pos, k, nrow;
    w = clamped(grid_w);
    h = clamped(grid_h);
    if (w == 0 || h == 0 || idx >= w * h)
      return idx;
    r = idx / w;
    c = idx % w;
    d = r + c;
    top = (d > w - 1) ? d - (w - 1) : 0;
    bottom = (d < h - 1) ? d : h - 1;
    len = bottom - top + 1;
    pos = r - top;
    k = rot_shift % len;
    if (rot_back)
      pos = (pos + len - k) % len;
    else
      pos = (pos + k) % len;
    nrow = top + pos;
    return IDX_W'(nrow * w + (d - nrow));
  endfunction

  function automatic logic [7:0] dim_draw();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0)
      return 8'($urandom_range(0, 255));
    else if (pick == 1)
      return 8'(GRID_LIMIT);
    else
      return 8'($urandom_range(1, GRID_LIMIT));
  endfunction

  task automatic drain();
    cell_bus.valid <= 1'b0;
    while (pending_cells.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(arp_pkg::reg_sel_t sel, logic [7:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic apply_grid(logic [7:0] w, logic [7:0] h, logic [7:0] s, logic [7:0] b);
    drain();
    write_reg(arp_pkg::REG_GRID_WIDTH, w);
    write_reg(arp_pkg::REG_GRID_HEIGHT, h);
    write_reg(arp_pkg::REG_SHIFT_AMOUNT, s);
    write_reg(arp_pkg::REG_DECRYPT_MODE, b);
    cfg_we <= 1'b0;
    grid_w    = w[DIM_CFG_W-1:0];
    grid_h    = h[DIM_CFG_W-1:0];
    rot_shift = s;
    rot_back  = b[0];
  endtask

  task automatic send_cell(logic [IDX_W-1:0] idx, logic [CHAR_W-1:0] ch, bit known,
                           logic [IDX_W-1:0] dest);
    int gap;
    cell_result_t e;
    if ($urandom_range(0, 39) == 0)
      send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      cell_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    e.dest = known ? dest : rotated_cell(idx);
    e.ch = ch;
    cell_bus.valid      <= 1'b1;
    cell_bus.cell_index <= idx;
    cell_bus.char_in    <= ch;
    @(posedge clk);
    while (!cell_bus.ready)
      @(posedge clk);
    pending_cells.push_back(e);
  endtask

  // result side
  initial begin
    int gap;
    cell_result_t e;
    dest_bus.ready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      if ($urandom_range(0, 39) == 0)
        take_calm = !take_calm;
      gap = take_calm ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        dest_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      dest_bus.ready <= 1'b1;
      @(posedge clk);
      while (!dest_bus.valid)
        @(posedge clk);
      if (pending_cells.size() == 0) begin
        $error("dest transaction with nothing expected: dest_index %0d char_out %0d",
               dest_bus.dest_index, dest_bus.char_out);
        mismatches++;
      end else begin
        e = pending_cells.pop_front();
        if (dest_bus.dest_index !== e.dest) begin
          $error("dest_index: expected %0d, got %0d", e.dest, dest_bus.dest_index);
          mismatches++;
        end
        if (dest_bus.char_out !== e.ch) begin
          $error("char_out: expected %0d, got %0d", e.ch, dest_bus.char_out);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int i, p, n;
    int unsigned cells;
    logic [IDX_W-1:0] idx;

    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_index           <= arp_pkg::REG_GRID_WIDTH;
    cfg_data            <= '0;
    cell_bus.valid      <= 1'b0;
    cell_bus.cell_index <= '0;
    cell_bus.char_in    <= '0;
    grid_w    = arp_pkg::GRID_WIDTH_RST;
    grid_h    = arp_pkg::GRID_HEIGHT_RST;
    rot_shift = arp_pkg::SHIFT_RST;
    rot_back  = 1'b0;

    //         set  w    h    shift back idx   ch     known dest
    plan = '{
      '{1'b0, 8'd0,   8'd0,   8'd0,   8'd0, 12'd0,    8'h00, 1'b1, 12'd0},
      '{1'b0, 8'd0,   8'd0,   8'd0,   8'd0, 12'd63,   8'hff, 1'b1, 12'd63},
      '{1'b0, 8'd0,   8'd0,   8'd0,   8'd0, 12'd64,   8'h5a, 1'b1, 12'd64},
      '{1'b0, 8'd0,   8'd0,   8'd0,   8'd0, 12'd4095, 8'ha5, 1'b1, 12'd4095},
      '{1'b0, 8'd0,   8'd0,   8'd0,   8'd0, 12'd7,    8'h41, 1'b0, 12'd0},
      '{1'b0, 8'd0,   8'd0,   8'd0,   8'd0, 12'd36,   8'h7e, 1'b0, 12'd0},
      '{1'b1, 8'd8,   8'd8,   8'd3,   8'd1, 12'd28,   8'h01, 1'b0, 12'd0},
      '{1'b0, 8'd0,   8'd0,   8'd0,   8'd0, 12'd7,    8'h02, 1'b0, 12'd0},
      // single column
      '{1'b1, 8'd1,   8'd16,  8'd5,   8'd0, 12'd5,    8'h33, 1'b1, 12'd5},
      '{1'b0, 8'd0,   8'd0,   8'd0,   8'd0, 12'd15,   8'h80, 1'b1, 12'd15},
      '{1'b0, 8'd0,   8'd0,   8'd0,   8'd0, 12'd16,   8'h7f, 1'b1, 12'd16},
      // zero width, zero height
      '{1'b1, 8'd0,   8'd8,   8'd3,   8'd0, 12'd3,    8'h11, 1'b1, 12'd3},
      '{1'b1, 8'd8,   8'd0,   8'd3,   8'd0, 12'd0,    8'h22, 1'b1, 12'd0},
      // oversized dimensions clamp to the largest grid
      '{1'b1, 8'd127, 8'd127, 8'd255, 8'd1, 12'd4095, 8'h44, 1'b1, 12'd4095},
      '{1'b0, 8'd0,   8'd0,   8'd0,   8'd0, 12'd4094, 8'h55, 1'b0, 12'd0},
      '{1'b0, 8'd0,   8'd0,   8'd0,   8'd0, 12'd63,   8'h66, 1'b0, 12'd0},
      '{1'b0, 8'd0,   8'd0,   8'd0,   8'd0, 12'd2080, 8'h77, 1'b0, 12'd0},
      '{1'b1, 8'd64,  8'd1,   8'd200, 8'd0, 12'd10,   8'h88, 1'b0, 12'd0},
      '{1'b1, 8'd2,   8'd64,  8'd0,   8'd1, 12'd77,   8'h99, 1'b1, 12'd77},
      '{1'b1, 8'd2,   8'd64,  8'd1,   8'd0, 12'd1,    8'haa, 1'b0, 12'd0},
      '{1'b1, 8'd65,  8'd3,   8'd128, 8'd0, 12'd100,  8'hbb, 1'b0, 12'd0},
      '{1'b1, 8'd5,   8'd7,   8'd255, 8'd1, 12'd34,   8'hcc, 1'b1, 12'd34},
      '{1'b0, 8'd0,   8'd0,   8'd0,   8'd0, 12'd35,   8'hdd, 1'b1, 12'd35}
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < PLAN_ROWS; i++) begin
      if (plan[i].set_grid)
        apply_grid(plan[i].w, plan[i].h, plan[i].shift, plan[i].back);
      send_cell(plan[i].idx, plan[i].ch, plan[i].known, plan[i].dest);
    end

    for (p = 0; p < PHASES; p++) begin
      apply_grid(dim_draw(), dim_draw(), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)));
      cells = clamped(grid_w) * clamped(grid_h);
      for (n = 0; n < PHASE_CELLS; n++) begin
        if ($urandom_range(0, 59) == 0)
          drain();
        if (cells > 0 && $urandom_range(0, 9) != 0)
          idx = IDX_W'($urandom_range(0, cells - 1));
        else
          idx = IDX_W'($urandom_range(0, 4095));
        send_cell(idx, CHAR_W'($urandom_range(0, 255)), 1'b0, '0);
      end
    end

    drain();
    repeat (40) @(posedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
